@@ sv/saturating_integer_alu_unit_assert.svh @@
// assertion macros for the rtl; salu_back is the file that includes them
`ifndef SATURATING_INTEGER_ALU_UNIT_ASSERT_SVH
`define SATURATING_INTEGER_ALU_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SALU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("saturating alu: assertion failed");

// antecedent implies consequent in the next cycle
`define SALU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("saturating alu: assertion failed");

`endif

@@ sv/salu_pkg.sv @@
`default_nettype none
package salu_pkg;

  // width of the operand and result fields on the ports
  localparam int OPW = 32;
  // default internal datapath width
  localparam int DEFAULT_WIDTH = 32;

  typedef enum logic [2:0] {
    OP_ADDU = 3'd0,
    OP_SUBU = 3'd1,
    OP_DIVU = 3'd2,
    OP_MULU = 3'd3,
    OP_ADDS = 3'd4,
    OP_SUBS = 3'd5,
    OP_DIVS = 3'd6,
    OP_MULS = 3'd7
  } op_e;

  // control carried alongside the datapath through the chain
  typedef struct packed {
    op_e  op;
    logic neg;
    logic sa;
    logic dz;
  } ctrl_t;

endpackage
`default_nettype wire

@@ sv/salu_front.sv @@
`default_nettype none
module salu_front #(
  parameter int WIDTH = salu_pkg::DEFAULT_WIDTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire logic [2:0]               cmd_i,
  input  wire logic [salu_pkg::OPW-1:0] opa_i,
  input  wire logic [salu_pkg::OPW-1:0] opb_i,
  output logic                          valid_o,
  output salu_pkg::ctrl_t               ctrl_o,
  output logic [WIDTH-1:0]              ma_o,
  output logic [WIDTH-1:0]              mb_o,
  output logic [WIDTH-1:0]              simple_o
);

  localparam logic [WIDTH-1:0] VMASK = {WIDTH{1'b1}};
  localparam logic [WIDTH-1:0] SMAXV = VMASK >> 1;
  localparam logic [WIDTH-1:0] SIGNB = ~SMAXV;

  logic [WIDTH-1:0] a, b;
  logic             sa, sb, sgn;
  logic [WIDTH:0]   sum, dif;
  logic [WIDTH-1:0] simple_d, ma_d, mb_d;
  salu_pkg::ctrl_t  ctrl_d;
  salu_pkg::op_e    op;
  logic             valid_q;
  salu_pkg::ctrl_t  ctrl_q;
  logic [WIDTH-1:0] ma_q, mb_q, simple_q;

  // fit the port operands to the datapath width
  if (WIDTH > salu_pkg::OPW) begin : g_ext
    assign a = {{(WIDTH - salu_pkg::OPW){1'b0}}, opa_i};
    assign b = {{(WIDTH - salu_pkg::OPW){1'b0}}, opb_i};
  end else begin : g_cut
    assign a = opa_i[WIDTH-1:0];
    assign b = opb_i[WIDTH-1:0];
  end

  assign op  = salu_pkg::op_e'(cmd_i);
  assign sa  = a[WIDTH-1];
  assign sb  = b[WIDTH-1];
  assign sgn = cmd_i[2];
  assign sum = {1'b0, a} + {1'b0, b};
  assign dif = {1'b0, a} - {1'b0, b};

  // add and subtract results, magnitudes for the chain
  always_comb begin
    case (op)
      salu_pkg::OP_ADDU: simple_d = sum[WIDTH] ? VMASK : sum[WIDTH-1:0];
      salu_pkg::OP_SUBU: simple_d = dif[WIDTH] ? '0 : dif[WIDTH-1:0];
      salu_pkg::OP_ADDS: simple_d = (sa == sb && sum[WIDTH-1] != sa) ?
                                    (sa ? SIGNB : SMAXV) : sum[WIDTH-1:0];
      salu_pkg::OP_SUBS: simple_d = (sa != sb && dif[WIDTH-1] != sa) ?
                                    (sa ? SIGNB : SMAXV) : dif[WIDTH-1:0];
      default:           simple_d = '0;
    endcase
    ma_d = (sgn && sa) ? (~a + 1'b1) : a;
    mb_d = (sgn && sb) ? (~b + 1'b1) : b;
    ctrl_d.op  = op;
    ctrl_d.neg = sa ^ sb;
    ctrl_d.sa  = sa;
    ctrl_d.dz  = (op == salu_pkg::OP_DIVU || op == salu_pkg::OP_DIVS) && (b == '0);
  end

  // control stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q   <= ctrl_d;
      ma_q     <= ma_d;
      mb_q     <= mb_d;
      simple_q <= simple_d;
    end
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign ma_o     = ma_q;
  assign mb_o     = mb_q;
  assign simple_o = simple_q;

endmodule
`default_nettype wire

@@ sv/salu_cell.sv @@
`default_nettype none
module salu_cell #(
  parameter int WIDTH = salu_pkg::DEFAULT_WIDTH,
  parameter int IDX   = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire salu_pkg::ctrl_t    ctrl_i,
  input  wire logic [WIDTH-1:0]   ma_i,
  input  wire logic [WIDTH-1:0]   mb_i,
  input  wire logic [WIDTH-1:0]   rem_i,
  input  wire logic [WIDTH-1:0]   quo_i,
  input  wire logic [2*WIDTH-1:0] acc_i,
  input  wire logic [WIDTH-1:0]   simple_i,
  output logic                    valid_o,
  output salu_pkg::ctrl_t         ctrl_o,
  output logic [WIDTH-1:0]        ma_o,
  output logic [WIDTH-1:0]        mb_o,
  output logic [WIDTH-1:0]        rem_o,
  output logic [WIDTH-1:0]        quo_o,
  output logic [2*WIDTH-1:0]      acc_o,
  output logic [WIDTH-1:0]        simple_o
);

  // this cell handles one bit, most significant first
  localparam int K = WIDTH - 1 - IDX;

  logic [WIDTH:0]     trial, diff;
  logic [WIDTH-1:0]   rem_d, quo_d;
  logic [2*WIDTH-1:0] acc_d;
  logic               valid_q;
  salu_pkg::ctrl_t    ctrl_q;
  logic [WIDTH-1:0]   ma_q, mb_q, rem_q, quo_q, simple_q;
  logic [2*WIDTH-1:0] acc_q;

  // one restoring divide step and one shift-add multiply step
  always_comb begin
    trial = {rem_i, ma_i[K]};
    diff  = trial - {1'b0, mb_i};
    quo_d = quo_i;
    if (!diff[WIDTH]) begin
      rem_d    = diff[WIDTH-1:0];
      quo_d[K] = 1'b1;
    end else begin
      rem_d    = trial[WIDTH-1:0];
    end
    acc_d = acc_i;
    if (ma_i[K]) begin
      acc_d = acc_i + ({{WIDTH{1'b0}}, mb_i} << K);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_q   <= ctrl_i;
      ma_q     <= ma_i;
      mb_q     <= mb_i;
      rem_q    <= rem_d;
      quo_q    <= quo_d;
      acc_q    <= acc_d;
      simple_q <= simple_i;
    end
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign ma_o     = ma_q;
  assign mb_o     = mb_q;
  assign rem_o    = rem_q;
  assign quo_o    = quo_q;
  assign acc_o    = acc_q;
  assign simple_o = simple_q;

endmodule
`default_nettype wire

@@ sv/salu_back.sv @@
`default_nettype none
`include "saturating_integer_alu_unit_assert.svh"
module salu_back #(
  parameter int WIDTH = salu_pkg::DEFAULT_WIDTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire salu_pkg::ctrl_t          ctrl_i,
  input  wire logic [WIDTH-1:0]         quo_i,
  input  wire logic [2*WIDTH-1:0]       acc_i,
  input  wire logic [WIDTH-1:0]         simple_i,
  output logic                          valid_o,
  output logic [salu_pkg::OPW-1:0]      result_o,
  output logic                          dz_o
);

  localparam logic [WIDTH-1:0] VMASK = {WIDTH{1'b1}};
  localparam logic [WIDTH-1:0] SMAXV = VMASK >> 1;
  localparam logic [WIDTH-1:0] SIGNB = ~SMAXV;

  logic [WIDTH-1:0] res_d, lim, sat_n, sat_a;
  logic             valid_q, dz_q;
  logic [WIDTH-1:0] res_q;

  assign lim   = ctrl_i.neg ? SIGNB : SMAXV;
  assign sat_n = ctrl_i.neg ? SIGNB : SMAXV;
  assign sat_a = ctrl_i.sa ? SIGNB : SMAXV;

  // final saturation and sign fix-up
  always_comb begin
    case (ctrl_i.op)
      salu_pkg::OP_DIVU: res_d = ctrl_i.dz ? VMASK : quo_i;
      salu_pkg::OP_MULU: res_d = (acc_i[2*WIDTH-1:WIDTH] != '0) ? VMASK : acc_i[WIDTH-1:0];
      salu_pkg::OP_DIVS: begin
        if (ctrl_i.dz) begin
          res_d = sat_a;
        end else if (ctrl_i.neg) begin
          res_d = ~quo_i + 1'b1;
        end else begin
          res_d = (quo_i > SMAXV) ? SMAXV : quo_i;
        end
      end
      salu_pkg::OP_MULS: begin
        if (acc_i > {{WIDTH{1'b0}}, lim}) begin
          res_d = sat_n;
        end else if (ctrl_i.neg) begin
          res_d = ~acc_i[WIDTH-1:0] + 1'b1;
        end else begin
          res_d = acc_i[WIDTH-1:0];
        end
      end
      default: res_d = simple_i;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      dz_q  <= ctrl_i.dz;
    end
  end

  if (WIDTH > salu_pkg::OPW) begin : g_cut
    assign result_o = res_q[salu_pkg::OPW-1:0];
  end else if (WIDTH == salu_pkg::OPW) begin : g_same
    assign result_o = res_q;
  end else begin : g_ext
    assign result_o = {{(salu_pkg::OPW - WIDTH){1'b0}}, res_q};
  end

  assign valid_o = valid_q;
  assign dz_o    = dz_q;

  // zero divisor always yields a saturated value
  `SALU_ASSERT_IMP(a_dz_sat, valid_q && dz_q, res_q == VMASK || res_q == SMAXV || res_q == SIGNB)
  // a valid item reaching the end is registered when the chain moves
  `SALU_ASSERT_NXT(a_adv, en_i && valid_i, valid_q)
  // a held output keeps its value while the chain is stalled
  `SALU_ASSERT_NXT(a_hold, !en_i && valid_q, valid_q && $stable(res_q) && $stable(dz_q))

endmodule
`default_nettype wire

@@ sv/saturating_integer_alu_unit.sv @@
// Saturating integer ALU: eight operations (unsigned and signed add, subtract,
// divide, multiply) on WIDTH-bit operands, clamped to range instead of
// wrapping. A divide by zero raises the tuser flag and returns the saturated
// value in the dividend's direction. The unit accepts one transfer per cycle
// while the output is not stalled. The path has one front stage, which
// registers the input when the chain moves, then a chain of WIDTH cells that
// each resolve one quotient bit and one multiply partial product, and then
// an output register. A stall at the output holds the whole chain.
`default_nettype none
module saturating_integer_alu_unit #(
  parameter int WIDTH = salu_pkg::DEFAULT_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // cmd[2:0], operand_a[34:3], operand_b[66:35], zero pad [71:67]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result[31:0]
  output logic [31:0]      m_axis_tdata,
  // divide_by_zero[0]
  output logic [0:0]       m_axis_tuser
);

  logic               en;
  logic               valid_c  [WIDTH+1];
  salu_pkg::ctrl_t    ctrl_c   [WIDTH+1];
  logic [WIDTH-1:0]   ma_c     [WIDTH+1];
  logic [WIDTH-1:0]   mb_c     [WIDTH+1];
  logic [WIDTH-1:0]   rem_c    [WIDTH+1];
  logic [WIDTH-1:0]   quo_c    [WIDTH+1];
  logic [2*WIDTH-1:0] acc_c    [WIDTH+1];
  logic [WIDTH-1:0]   simple_c [WIDTH+1];
  logic               dz;

  // the chain moves whenever the output register is free or being drained
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  salu_front #(.WIDTH(WIDTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .cmd_i    (s_axis_tdata[2:0]),
    .opa_i    (s_axis_tdata[34:3]),
    .opb_i    (s_axis_tdata[66:35]),
    .valid_o  (valid_c[0]),
    .ctrl_o   (ctrl_c[0]),
    .ma_o     (ma_c[0]),
    .mb_o     (mb_c[0]),
    .simple_o (simple_c[0])
  );

  // divider and multiplier start from zero partials
  assign rem_c[0] = '0;
  assign quo_c[0] = '0;
  assign acc_c[0] = '0;

  // row of cells, one bit per cell
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    salu_cell #(.WIDTH(WIDTH), .IDX(i)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (valid_c[i]),
      .ctrl_i   (ctrl_c[i]),
      .ma_i     (ma_c[i]),
      .mb_i     (mb_c[i]),
      .rem_i    (rem_c[i]),
      .quo_i    (quo_c[i]),
      .acc_i    (acc_c[i]),
      .simple_i (simple_c[i]),
      .valid_o  (valid_c[i+1]),
      .ctrl_o   (ctrl_c[i+1]),
      .ma_o     (ma_c[i+1]),
      .mb_o     (mb_c[i+1]),
      .rem_o    (rem_c[i+1]),
      .quo_o    (quo_c[i+1]),
      .acc_o    (acc_c[i+1]),
      .simple_o (simple_c[i+1])
    );
  end

  salu_back #(.WIDTH(WIDTH)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_c[WIDTH]),
    .ctrl_i   (ctrl_c[WIDTH]),
    .quo_i    (quo_c[WIDTH]),
    .acc_i    (acc_c[WIDTH]),
    .simple_i (simple_c[WIDTH]),
    .valid_o  (m_axis_tvalid),
    .result_o (m_axis_tdata),
    .dz_o     (dz)
  );

  assign m_axis_tuser = dz;

endmodule
`default_nettype wire
